[src/lsps_pkg.sv]
// shared types, widths and constants for the line segment point stepper
package lsps_pkg;

    localparam int CoordW   = 13;                 // q5.8 coordinate field
    localparam int MagW     = CoordW;             // magnitude of a coordinate difference
    localparam int SqW      = 2 * MagW;           // one squared magnitude
    localparam int SumW     = SqW + 2;            // sum of two squares, even bit count
    localparam int LenW     = SumW / 2;           // integer square root
    localparam int QuotW    = MagW + 8;           // difference in q.16 and its quotient
    localparam int StepW    = QuotW + 1;          // signed q.16 step
    localparam int AccW     = StepW + 2;          // q.16 point accumulator
    localparam int UnitW    = SumW + 2;           // shared subtractor width
    localparam int IterW    = $clog2(QuotW);
    localparam int SpuW     = 4;
    localparam int SpuReset = 5;
    localparam int InDataW  = 56;
    localparam int OutDataW = 32;
    localparam int OutUserW = 2;

    localparam int MaxStepsDefault = 64;

    typedef enum logic [3:0] {
        SV_IDLE,
        SV_SQ_X,
        SV_SQ_Y,
        SV_SQRT,
        SV_COUNT,
        SV_LOAD_X,
        SV_DIV_X,
        SV_LOAD_Y,
        SV_DIV_Y,
        SV_DONE
    } solve_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_SOLVE,
        TS_EMIT
    } top_state_t;

    typedef struct packed {
        logic done;
        logic zero_len;
        logic no_count;
    } solve_status_t;

endpackage

[src/line_segment_point_stepper_unit.sv]
// top level: stream ports, register, point accumulator and result register
// Takes one segment per request and returns its run of points. After a request is
// accepted the solver squares each axis, finds the 14 square-root digits and the
// count, then 21 quotient digits for each axis (root and quotient digits all through
// one shared compare-subtract unit); the n points then leave at one per cycle while
// m_tready is high, n at most MAX_STEPS. A zero-length segment returns one result
// with success low; a segment whose count rounds to zero returns one result with no
// point. s_tready is low from acceptance until the run's last result has been
// loaded into the output register. steps_per_unit is to be written through
// cfg_wr_en and cfg_wr_data only while idle; the block itself does not enforce this.
module line_segment_point_stepper_unit #(
    parameter int MAX_STEPS = lsps_pkg::MaxStepsDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lsps_pkg::SpuW-1:0]       cfg_wr_data,   // steps_per_unit
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsps_pkg::InDataW-1:0]    s_tdata,       // start_x, start_y, end_x, end_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsps_pkg::OutDataW-1:0]   m_tdata,       // point_x, point_y
    output logic [lsps_pkg::OutUserW-1:0]   m_tuser,       // point_valid, success
    output logic                            m_tlast
);

    localparam int CoordW = lsps_pkg::CoordW;
    localparam int StepW  = lsps_pkg::StepW;
    localparam int AccW   = lsps_pkg::AccW;
    localparam int CountW = $clog2(MAX_STEPS + 1);

    lsps_pkg::top_state_t    state_reg, state_next;
    lsps_pkg::solve_status_t solve_status;

    logic [lsps_pkg::SpuW-1:0] spu_reg;
    logic signed [AccW-1:0]    acc_x_reg, acc_y_reg;
    logic [CountW-1:0]         left_reg;
    logic                      special_reg, success_reg;
    logic                      m_valid_reg, m_last_reg, m_point_valid_reg, m_success_reg;
    logic [CoordW-1:0]         m_x_reg, m_y_reg;

    logic                      in_req, out_free;
    logic [CountW-1:0]         solve_count;
    logic signed [StepW-1:0]   solve_step_x, solve_step_y;
    logic signed [AccW-1:0]    acc_x_sum, acc_y_sum, round_x, round_y;
    logic signed [CoordW-1:0]  in_start_x, in_start_y, in_end_x, in_end_y;

    assign in_start_x = s_tdata[CoordW-1:0];
    assign in_start_y = s_tdata[2*CoordW-1:CoordW];
    assign in_end_x   = s_tdata[3*CoordW-1:2*CoordW];
    assign in_end_y   = s_tdata[4*CoordW-1:3*CoordW];

    assign s_tready = (state_reg == lsps_pkg::TS_IDLE);
    assign in_req   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    lsps_solver #(
        .MAX_STEPS (MAX_STEPS),
        .CountW    (CountW)
    ) u_solver (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (in_req),
        .start_x        (in_start_x),
        .start_y        (in_start_y),
        .end_x          (in_end_x),
        .end_y          (in_end_y),
        .steps_per_unit (spu_reg),
        .status         (solve_status),
        .count          (solve_count),
        .step_x         (solve_step_x),
        .step_y         (solve_step_y)
    );

    assign acc_x_sum = acc_x_reg + AccW'(solve_step_x);
    assign acc_y_sum = acc_y_reg + AccW'(solve_step_y);
    // q.16 to q.8 with halves rounded up
    assign round_x   = acc_x_sum + AccW'(128);
    assign round_y   = acc_y_sum + AccW'(128);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsps_pkg::TS_IDLE;
            spu_reg     <= lsps_pkg::SpuW'(lsps_pkg::SpuReset);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                spu_reg <= cfg_wr_data;
            end
            if (state_reg == lsps_pkg::TS_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsps_pkg::TS_IDLE: begin
                if (in_req) begin
                    state_next = lsps_pkg::TS_SOLVE;
                end
            end
            lsps_pkg::TS_SOLVE: begin
                if (solve_status.done) begin
                    state_next = lsps_pkg::TS_EMIT;
                end
            end
            lsps_pkg::TS_EMIT: begin
                if (out_free && (special_reg || left_reg == CountW'(1))) begin
                    state_next = lsps_pkg::TS_IDLE;
                end
            end
            default: state_next = lsps_pkg::TS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_req) begin
            acc_x_reg <= AccW'({in_start_x, 8'b0});
            acc_y_reg <= AccW'({in_start_y, 8'b0});
        end
        if (state_reg == lsps_pkg::TS_SOLVE && solve_status.done) begin
            special_reg <= solve_status.zero_len || solve_status.no_count;
            success_reg <= !solve_status.zero_len;
            left_reg    <= solve_count;
        end
        if (state_reg == lsps_pkg::TS_EMIT && out_free) begin
            if (special_reg) begin
                m_x_reg           <= '0;
                m_y_reg           <= '0;
                m_point_valid_reg <= 1'b0;
                m_success_reg     <= success_reg;
                m_last_reg        <= 1'b1;
            end else begin
                acc_x_reg         <= acc_x_sum;
                acc_y_reg         <= acc_y_sum;
                left_reg          <= left_reg - 1'b1;
                m_x_reg           <= round_x[CoordW+7:8];
                m_y_reg           <= round_y[CoordW+7:8];
                m_point_valid_reg <= 1'b1;
                m_success_reg     <= 1'b1;
                m_last_reg        <= (left_reg == CountW'(1));
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lsps_pkg::OutDataW'({m_y_reg, m_x_reg});
    assign m_tuser  = {m_success_reg, m_point_valid_reg};
    assign m_tlast  = m_last_reg;

endmodule

[src/lsps_solver.sv]
// iterative solver: squared length, integer square root, step count and step vector
module lsps_solver #(
    parameter int MAX_STEPS = lsps_pkg::MaxStepsDefault,
    parameter int CountW    = $clog2(MAX_STEPS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [lsps_pkg::CoordW-1:0]  start_x,
    input  logic signed [lsps_pkg::CoordW-1:0]  start_y,
    input  logic signed [lsps_pkg::CoordW-1:0]  end_x,
    input  logic signed [lsps_pkg::CoordW-1:0]  end_y,
    input  logic [lsps_pkg::SpuW-1:0]           steps_per_unit,
    output lsps_pkg::solve_status_t             status,
    output logic [CountW-1:0]                   count,
    output logic signed [lsps_pkg::StepW-1:0]   step_x,
    output logic signed [lsps_pkg::StepW-1:0]   step_y
);

    localparam int CoordW = lsps_pkg::CoordW;
    localparam int MagW   = lsps_pkg::MagW;
    localparam int SqW    = lsps_pkg::SqW;
    localparam int SumW   = lsps_pkg::SumW;
    localparam int LenW   = lsps_pkg::LenW;
    localparam int QuotW  = lsps_pkg::QuotW;
    localparam int StepW  = lsps_pkg::StepW;
    localparam int UnitW  = lsps_pkg::UnitW;
    localparam int IterW  = lsps_pkg::IterW;
    localparam int SpuW   = lsps_pkg::SpuW;
    localparam int RoundW = LenW + 1;
    localparam int UnitsW = RoundW - 8;
    localparam int ProdW  = UnitsW + SpuW;

    lsps_pkg::solve_state_t state_reg, state_next;

    logic [MagW-1:0]         adx_reg, ady_reg;
    logic                    neg_x_reg, neg_y_reg;
    logic [SumW-1:0]         sum_reg;
    logic [SumW-1:0]         root_reg;
    logic [SumW-1:0]         bit_reg;
    logic [IterW-1:0]        iter_reg;
    logic [QuotW-1:0]        dvd_reg;
    logic [CountW-1:0]       rem_reg;
    logic [CountW-1:0]       count_reg;
    logic signed [StepW-1:0] step_x_reg, step_y_reg;
    logic                    zero_len_reg, no_count_reg;

    logic signed [CoordW:0]  dx, dy;
    logic [MagW-1:0]         mul_op;
    logic [SqW-1:0]          square;
    logic [UnitW-1:0]        unit_a, unit_b, unit_diff;
    logic                    unit_ge;
    logic [CountW:0]         rem_shift;
    logic [QuotW-1:0]        quot_next;
    logic [RoundW-1:0]       len_round;
    logic [UnitsW-1:0]       units;
    logic [ProdW-1:0]        raw_count;
    logic signed [StepW-1:0] quot_signed;

    assign dx = {end_x[CoordW-1], end_x} - {start_x[CoordW-1], start_x};
    assign dy = {end_y[CoordW-1], end_y} - {start_y[CoordW-1], start_y};

    // one multiplier squares both magnitudes in turn
    assign mul_op = (state_reg == lsps_pkg::SV_SQ_X) ? adx_reg : ady_reg;
    assign square = mul_op * mul_op;

    assign rem_shift = {rem_reg, dvd_reg[QuotW-1]};

    // shared compare-subtract for root and quotient digits
    always_comb begin
        if (state_reg == lsps_pkg::SV_SQRT) begin
            unit_a = UnitW'(sum_reg);
            unit_b = UnitW'(root_reg) + UnitW'(bit_reg);
        end else begin
            unit_a = UnitW'(rem_shift);
            unit_b = UnitW'(count_reg);
        end
        unit_diff = unit_a - unit_b;
        unit_ge   = ~unit_diff[UnitW-1];
    end

    assign quot_next   = {dvd_reg[QuotW-2:0], unit_ge};
    assign quot_signed = StepW'({1'b0, quot_next});

    assign len_round = RoundW'(root_reg[LenW-1:0]) + RoundW'(128);
    assign units     = len_round[RoundW-1:8];
    assign raw_count = ProdW'(units) * ProdW'(steps_per_unit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsps_pkg::SV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsps_pkg::SV_IDLE: begin
                if (start) begin
                    state_next = (dx == '0 && dy == '0) ? lsps_pkg::SV_DONE
                                                         : lsps_pkg::SV_SQ_X;
                end
            end
            lsps_pkg::SV_SQ_X:   state_next = lsps_pkg::SV_SQ_Y;
            lsps_pkg::SV_SQ_Y:   state_next = lsps_pkg::SV_SQRT;
            lsps_pkg::SV_SQRT: begin
                if (iter_reg == IterW'(LenW - 1)) begin
                    state_next = lsps_pkg::SV_COUNT;
                end
            end
            lsps_pkg::SV_COUNT: begin
                state_next = (raw_count == '0) ? lsps_pkg::SV_DONE : lsps_pkg::SV_LOAD_X;
            end
            lsps_pkg::SV_LOAD_X: state_next = lsps_pkg::SV_DIV_X;
            lsps_pkg::SV_DIV_X: begin
                if (iter_reg == IterW'(QuotW - 1)) begin
                    state_next = lsps_pkg::SV_LOAD_Y;
                end
            end
            lsps_pkg::SV_LOAD_Y: state_next = lsps_pkg::SV_DIV_Y;
            lsps_pkg::SV_DIV_Y: begin
                if (iter_reg == IterW'(QuotW - 1)) begin
                    state_next = lsps_pkg::SV_DONE;
                end
            end
            lsps_pkg::SV_DONE:   state_next = lsps_pkg::SV_IDLE;
            default:             state_next = lsps_pkg::SV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            lsps_pkg::SV_IDLE: begin
                adx_reg      <= dx[CoordW] ? MagW'(-dx) : MagW'(dx);
                ady_reg      <= dy[CoordW] ? MagW'(-dy) : MagW'(dy);
                neg_x_reg    <= dx[CoordW];
                neg_y_reg    <= dy[CoordW];
                zero_len_reg <= (dx == '0 && dy == '0);
                no_count_reg <= 1'b0;
            end
            lsps_pkg::SV_SQ_X: begin
                sum_reg <= SumW'(square);
            end
            lsps_pkg::SV_SQ_Y: begin
                sum_reg  <= sum_reg + SumW'(square);
                root_reg <= '0;
                bit_reg  <= SumW'(1) << (SumW - 2);
                iter_reg <= '0;
            end
            lsps_pkg::SV_SQRT: begin
                if (unit_ge) begin
                    sum_reg  <= unit_diff[SumW-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                iter_reg <= iter_reg + 1'b1;
            end
            lsps_pkg::SV_COUNT: begin
                no_count_reg <= (raw_count == '0);
                count_reg    <= (raw_count > ProdW'(MAX_STEPS)) ? CountW'(MAX_STEPS)
                                                                : CountW'(raw_count);
            end
            lsps_pkg::SV_LOAD_X, lsps_pkg::SV_LOAD_Y: begin
                dvd_reg  <= (state_reg == lsps_pkg::SV_LOAD_X) ? {adx_reg, 8'b0}
                                                               : {ady_reg, 8'b0};
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            lsps_pkg::SV_DIV_X, lsps_pkg::SV_DIV_Y: begin
                rem_reg  <= unit_ge ? unit_diff[CountW-1:0] : rem_shift[CountW-1:0];
                dvd_reg  <= quot_next;
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IterW'(QuotW - 1)) begin
                    if (state_reg == lsps_pkg::SV_DIV_X) begin
                        step_x_reg <= neg_x_reg ? -quot_signed : quot_signed;
                    end else begin
                        step_y_reg <= neg_y_reg ? -quot_signed : quot_signed;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign status.done     = (state_reg == lsps_pkg::SV_DONE);
    assign status.zero_len = zero_len_reg;
    assign status.no_count = no_count_reg;
    assign count           = count_reg;
    assign step_x          = step_x_reg;
    assign step_y          = step_y_reg;

endmodule

[tb/lsps_point_checker.sv]
// point checker for the line segment point stepper: predicts each run of points and compares
module lsps_point_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lsps_pkg::SpuW-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lsps_pkg::InDataW-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lsps_pkg::OutDataW-1:0]   m_tdata,
    input  logic [lsps_pkg::OutUserW-1:0]   m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              points_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CoordW  = lsps_pkg::CoordW;
    localparam int SpuW    = lsps_pkg::SpuW;
    localparam int InDataW = lsps_pkg::InDataW;

    typedef struct packed {
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;
        logic              pvalid;
        logic              ok;
        logic              last;
    } seg_point_t;

    seg_point_t          point_q[$];
    logic [SpuW-1:0]     steps_per_unit;

    initial begin
        fail_count     = 0;
        points_pending = 0;
    end

    function automatic int unsigned int_sqrt(input int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res  = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // q.8 difference to a q.16 step, truncated toward zero
    function automatic longint step_q16(input int d, input int unsigned n);
        int unsigned mag;
        mag = (d < 0 ? -d : d) << 8;
        return d < 0 ? -longint'(mag / n) : longint'(mag / n);
    endfunction

    task automatic predict_run(input logic [InDataW-1:0] seg);
        int          sx, sy, dx, dy;
        int unsigned adx, ady, len, n;
        longint      ax, ay, stx, sty, rx, ry;
        seg_point_t  pt;
        sx = $signed(seg[CoordW-1:0]);
        sy = $signed(seg[2*CoordW-1:CoordW]);
        dx = int'($signed(seg[3*CoordW-1:2*CoordW])) - sx;
        dy = int'($signed(seg[4*CoordW-1:3*CoordW])) - sy;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        pt  = '0;
        pt.last = 1'b1;
        if (adx == 0 && ady == 0) begin
            point_q.push_back(pt);
            return;
        end
        len = int_sqrt(adx * adx + ady * ady);
        n   = ((len + 128) >> 8) * steps_per_unit;
        if (n > lsps_pkg::MaxStepsDefault) n = lsps_pkg::MaxStepsDefault;
        pt.ok = 1'b1;
        if (n == 0) begin
            point_q.push_back(pt);
            return;
        end
        stx = step_q16(dx, n);
        sty = step_q16(dy, n);
        ax  = longint'(sx) * 256;
        ay  = longint'(sy) * 256;
        for (int k = 0; k < n; k++) begin
            ax = ax + stx;
            ay = ay + sty;
            // round to q.8 with halves toward plus infinity
            rx = (ax + 128) >>> 8;
            ry = (ay + 128) >>> 8;
            pt.px     = rx[CoordW-1:0];
            pt.py     = ry[CoordW-1:0];
            pt.pvalid = 1'b1;
            pt.last   = (k == n - 1);
            point_q.push_back(pt);
        end
    endtask

    always @(posedge aclk) begin
        seg_point_t want, got;
        if (!aresetn) begin
            steps_per_unit = SpuW'(lsps_pkg::SpuReset);
            point_q.delete();
        end else begin
            if (cfg_wr_en) steps_per_unit = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.px     = m_tdata[CoordW-1:0];
                got.py     = m_tdata[2*CoordW-1:CoordW];
                got.pvalid = m_tuser[0];
                got.ok     = m_tuser[1];
                got.last   = m_tlast;
                if (point_q.size() == 0) begin
                    $display("%0t: unexpected point x=%0d y=%0d valid=%0b ok=%0b last=%0b",
                             $time, $signed(got.px), $signed(got.py), got.pvalid, got.ok,
                             got.last);
                    fail_count++;
                end else begin
                    want = point_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected x=%0d y=%0d valid=%0b ok=%0b last=%0b",
                                 $time, $signed(want.px), $signed(want.py), want.pvalid,
                                 want.ok, want.last);
                        $display("%0t: actual   x=%0d y=%0d valid=%0b ok=%0b last=%0b",
                                 $time, $signed(got.px), $signed(got.py), got.pvalid,
                                 got.ok, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_run(s_tdata);
        end
        points_pending <= point_q.size();
    end

endmodule

[tb/tb_top.sv]
// testbench top for the line segment point stepper: stimulus, reset and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 600000;
    localparam int NumDirected = 22;
    localparam int CoordW   = lsps_pkg::CoordW;
    localparam int SpuW     = lsps_pkg::SpuW;
    localparam int InDataW  = lsps_pkg::InDataW;
    localparam int OutDataW = lsps_pkg::OutDataW;
    localparam int OutUserW = lsps_pkg::OutUserW;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [SpuW-1:0]       cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OutDataW-1:0]   m_tdata;
    logic [OutUserW-1:0]   m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    points_pending;
    int                    cycle_count = 0;
    logic                  calm        = 1'b0;

    // start_x, start_y, end_x, end_y
    int seg_list[NumDirected][4] = '{
        '{0, 0, 0, 0},
        '{-4096, -4096, -4096, -4096},
        '{4095, 4095, 4095, 4095},
        '{0, 0, 127, 0},
        '{0, 0, 0, -128},
        '{-4096, -4096, 4095, 4095},
        '{4095, 4095, -4096, -4096},
        '{4095, -4096, -4096, 4095},
        '{0, 0, 256, 0},
        '{100, -100, 483, -100},
        '{0, 0, -384, 0},
        '{-4096, 0, 4095, 0},
        '{0, -4096, 0, 4095},
        '{3, 5, 93, 95},
        '{3, 5, 94, 96},
        '{-1, -1, -2, -3},
        '{10, -20, -700, 900},
        '{-2000, 1500, 1000, -1200},
        '{1, 0, 0, 0},
        '{0, 0, -128, -128},
        '{-7, 9, -135, 9},
        '{4000, -4000, 3616, -3616}
    };

    line_segment_point_stepper_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    lsps_point_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .points_pending (points_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int clamp_coord(input int v);
        return v > 4095 ? 4095 : (v < -4096 ? -4096 : v);
    endfunction

    function automatic logic [InDataW-1:0] pack_segment(input int sx, input int sy,
                                                        input int ex, input int ey);
        logic [CoordW-1:0] a, b, c, d;
        a = sx[CoordW-1:0];
        b = sy[CoordW-1:0];
        c = ex[CoordW-1:0];
        d = ey[CoordW-1:0];
        return {{(InDataW - 4*CoordW){1'b0}}, d, c, b, a};
    endfunction

    function automatic logic [InDataW-1:0] random_segment();
        int sx, sy, dx, dy, kind, span;
        kind = $urandom_range(9);
        sx   = $signed(13'($urandom()));
        sy   = $signed(13'($urandom()));
        dx   = 0;
        dy   = 0;
        if (kind <= 2) begin
            return pack_segment(sx, sy, $signed(13'($urandom())), $signed(13'($urandom())));
        end else if (kind <= 6) begin
            span = $urandom_range(1600, 40);
            dx = $urandom_range(2 * span) - span;
            dy = $urandom_range(2 * span) - span;
        end else if (kind == 7) begin
            // axis-aligned
            if ($urandom_range(1)) dx = $urandom_range(2400) - 1200;
            else dy = $urandom_range(2400) - 1200;
        end else if (kind == 9) begin
            // length near a half-unit rounding boundary
            dx = 256 * $urandom_range(7) + 128 + $urandom_range(4) - 2;
            if ($urandom_range(1)) dx = -dx;
            if ($urandom_range(1)) begin
                dy = dx;
                dx = 0;
            end
        end
        return pack_segment(sx, sy, clamp_coord(sx + dx), clamp_coord(sy + dy));
    endfunction

    task automatic send_segment(input logic [InDataW-1:0] seg);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (points_pending != 0);
    endtask

    task automatic write_steps_per_unit(input logic [SpuW-1:0] v);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [SpuW-1:0] spu_list[7];
        int              per_phase;
        spu_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd5};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NumDirected; i++) begin
            send_segment(pack_segment(seg_list[i][0], seg_list[i][1],
                                      seg_list[i][2], seg_list[i][3]));
        end

        for (int p = 0; p < 7; p++) begin
            write_steps_per_unit(spu_list[p]);
            // in the first phase, long runs of points with both sides always ready
            calm <= (p == 0);
            per_phase = (spu_list[p] == 0) ? 12 : 32;
            for (int i = 0; i < per_phase; i++) begin
                // hold off until the whole backlog has come out
                if (i == per_phase / 2 && p % 2 == 1) wait_drained();
                send_segment(random_segment());
            end
            calm <= 1'b0;
        end

        wait_drained();
        repeat (150) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
